// ----- design/ibqm_pkg.sv -----
// Shared constants, types, step table and saturating helpers for the quad map.
`default_nettype none
package ibqm_pkg;

   localparam int unsigned MAX_ITERATIONS = 10;
   localparam int unsigned ITER_W = $clog2(MAX_ITERATIONS + 1);
   localparam int unsigned FN = 30;       // normalized coordinate fraction bits
   localparam int unsigned FC = 22;       // corner and Jacobian fraction bits
   localparam int unsigned FOUT = 15;     // FN - 16 + 1 for the grid scale
   localparam int unsigned DIV_W = 64 + FN;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

   localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] RES_LIMIT = 64'sd1152921;
   localparam logic signed [63:0] ONE_N = 64'sd1 <<< FN;
   localparam logic signed [63:0] OUT_MAX = 64'sd281474976710655;
   localparam logic signed [63:0] OUT_MIN = -64'sd281474976710656;

   typedef logic signed [63:0] val_type;

   // request to the shared multiplier
   typedef struct packed {
      logic       start;
      logic [5:0] shift;
   } mul_req_type;

   // operand sources
   localparam logic [4:0] OP_X   = 5'd0;
   localparam logic [4:0] OP_Y   = 5'd1;
   localparam logic [4:0] OP_A   = 5'd2;
   localparam logic [4:0] OP_B   = 5'd3;
   localparam logic [4:0] OP_C   = 5'd4;
   localparam logic [4:0] OP_D   = 5'd5;
   localparam logic [4:0] OP_XY  = 5'd6;
   localparam logic [4:0] OP_P   = 5'd7;
   localparam logic [4:0] OP_Q   = 5'd8;
   localparam logic [4:0] OP_DX  = 5'd9;
   localparam logic [4:0] OP_DY  = 5'd10;
   localparam logic [4:0] OP_CX  = 5'd11;
   localparam logic [4:0] OP_CY  = 5'd12;
   localparam logic [4:0] OP_J1X = 5'd13;
   localparam logic [4:0] OP_J1Y = 5'd14;
   localparam logic [4:0] OP_K1X = 5'd15;
   localparam logic [4:0] OP_K1Y = 5'd16;
   localparam logic [4:0] OP_GW  = 5'd17;
   localparam logic [4:0] OP_GH  = 5'd18;
   localparam logic [4:0] OP_X1  = 5'd19;
   localparam logic [4:0] OP_Y1  = 5'd20;

   // accumulate bases
   localparam logic [3:0] BS_ZERO = 4'd0;
   localparam logic [3:0] BS_J1X  = 4'd1;
   localparam logic [3:0] BS_J1Y  = 4'd2;
   localparam logic [3:0] BS_K1X  = 4'd3;
   localparam logic [3:0] BS_K1Y  = 4'd4;
   localparam logic [3:0] BS_T    = 4'd5;
   localparam logic [3:0] BS_P    = 4'd6;
   localparam logic [3:0] BS_Q    = 4'd7;
   localparam logic [3:0] BS_P0   = 4'd8;
   localparam logic [3:0] BS_Q0   = 4'd9;

   // destinations
   localparam logic [3:0] DS_A   = 4'd0;
   localparam logic [3:0] DS_B   = 4'd1;
   localparam logic [3:0] DS_C   = 4'd2;
   localparam logic [3:0] DS_D   = 4'd3;
   localparam logic [3:0] DS_XY  = 4'd4;
   localparam logic [3:0] DS_T   = 4'd5;
   localparam logic [3:0] DS_DET = 4'd6;
   localparam logic [3:0] DS_P   = 4'd7;
   localparam logic [3:0] DS_Q   = 4'd8;
   localparam logic [3:0] DS_OX  = 4'd9;
   localparam logic [3:0] DS_OY  = 4'd10;

   // steps with follow-up actions
   localparam logic [4:0] ST_FIRST = 5'd0;
   localparam logic [4:0] ST_DET   = 5'd6;
   localparam logic [4:0] ST_DXN   = 5'd14;
   localparam logic [4:0] ST_DYN   = 5'd16;
   localparam logic [4:0] ST_SQ0   = 5'd17;
   localparam logic [4:0] ST_SQ    = 5'd18;
   localparam logic [4:0] ST_OY    = 5'd20;

   typedef struct packed {
      logic [4:0] a_sel;
      logic [4:0] b_sel;
      logic [3:0] base_sel;
      logic       sub;
      logic [5:0] shift;
      logic [3:0] dest;
   } step_type;

   // one multiply-accumulate per step: dest = base +/- (a*b >> shift)
   function automatic step_type step_info(input logic [4:0] s);
      step_type r;
      case (s)
         5'd0:  r = '{OP_Y,   OP_CX, BS_J1X, 1'b0, 6'(FN),   DS_A};
         5'd1:  r = '{OP_X,   OP_CX, BS_J1Y, 1'b0, 6'(FN),   DS_B};
         5'd2:  r = '{OP_Y,   OP_CY, BS_K1X, 1'b0, 6'(FN),   DS_C};
         5'd3:  r = '{OP_X,   OP_CY, BS_K1Y, 1'b0, 6'(FN),   DS_D};
         5'd4:  r = '{OP_X,   OP_Y,  BS_ZERO, 1'b0, 6'(FN),  DS_XY};
         5'd5:  r = '{OP_A,   OP_D,  BS_ZERO, 1'b0, 6'(FC),  DS_T};
         5'd6:  r = '{OP_C,   OP_B,  BS_T,   1'b1, 6'(FC),   DS_DET};
         5'd7:  r = '{OP_J1X, OP_X,  BS_P0,  1'b1, 6'(FN),   DS_P};
         5'd8:  r = '{OP_J1Y, OP_Y,  BS_P,   1'b1, 6'(FN),   DS_P};
         5'd9:  r = '{OP_CX,  OP_XY, BS_P,   1'b1, 6'(FN),   DS_P};
         5'd10: r = '{OP_K1X, OP_X,  BS_Q0,  1'b1, 6'(FN),   DS_Q};
         5'd11: r = '{OP_K1Y, OP_Y,  BS_Q,   1'b1, 6'(FN),   DS_Q};
         5'd12: r = '{OP_CY,  OP_XY, BS_Q,   1'b1, 6'(FN),   DS_Q};
         5'd13: r = '{OP_D,   OP_P,  BS_ZERO, 1'b0, 6'(FC),  DS_T};
         5'd14: r = '{OP_B,   OP_Q,  BS_T,   1'b1, 6'(FC),   DS_T};
         5'd15: r = '{OP_A,   OP_Q,  BS_ZERO, 1'b0, 6'(FC),  DS_T};
         5'd16: r = '{OP_C,   OP_P,  BS_T,   1'b1, 6'(FC),   DS_T};
         5'd17: r = '{OP_DX,  OP_DX, BS_ZERO, 1'b0, 6'd0,    DS_T};
         5'd18: r = '{OP_DY,  OP_DY, BS_T,   1'b0, 6'd0,     DS_T};
         5'd19: r = '{OP_X1,  OP_GW, BS_ZERO, 1'b0, 6'(FOUT), DS_OX};
         5'd20: r = '{OP_Y1,  OP_GH, BS_ZERO, 1'b0, 6'(FOUT), DS_OY};
         default: r = '{OP_X, OP_X, BS_ZERO, 1'b0, 6'd0, DS_T};
      endcase
      return r;
   endfunction

   // clamp a 65-bit sum to +-SMAX
   function automatic val_type sat65(input logic signed [64:0] v);
      val_type r;
      if (v > 65'(SMAX)) r = SMAX;
      else if (v < -65'(SMAX)) r = -SMAX;
      else r = v[63:0];
      return r;
   endfunction

   function automatic val_type sat_add(input val_type a, input val_type b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      return sat65(s);
   endfunction

   function automatic logic [63:0] mag64(input val_type a);
      logic [63:0] r;
      r = a[63] ? (64'd0 - 64'(a)) : 64'(a);
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- design/ibqm_mul.sv -----
// Shared multiplier: exact 64x64 magnitude product from four 32x32 partials, shift, saturate.
`default_nettype none
module ibqm_mul (
   input  wire                    clock,
   input  wire                    reset,
   input  ibqm_pkg::mul_req_type  req,
   input  ibqm_pkg::val_type      op_a,
   input  ibqm_pkg::val_type      op_b,
   output logic                   done,
   output ibqm_pkg::val_type      result
);

   logic [63:0]  ua_ff, ub_ff;
   logic         neg_ff;
   logic [5:0]   sh_ff;
   logic [127:0] acc_ff, acc_in;
   logic [2:0]   cnt_ff;
   logic         busy_ff, done_ff;
   ibqm_pkg::val_type res_ff, res_in;

   logic [31:0]  pa, pb;
   logic [63:0]  pp;
   logic [127:0] pp_w, sh_w;
   logic [63:0]  mag_w;

   // partial product for the current pass
   always_comb begin
      pa = cnt_ff[1] ? ua_ff[63:32] : ua_ff[31:0];
      pb = cnt_ff[0] ? ub_ff[63:32] : ub_ff[31:0];
      pp = 64'(pa) * 64'(pb);
      case ({cnt_ff[1], cnt_ff[0]})
         2'b00:   pp_w = 128'(pp);
         2'b11:   pp_w = 128'(pp) << 64;
         default: pp_w = 128'(pp) << 32;
      endcase
      acc_in = acc_ff + pp_w;
   end

   // shift, truncate toward zero, saturate, apply sign
   always_comb begin
      sh_w = acc_ff >> sh_ff;
      if (sh_w[127:64] != 64'd0 || sh_w[63]) mag_w = 64'(ibqm_pkg::SMAX);
      else mag_w = sh_w[63:0];
      res_in = neg_ff ? -ibqm_pkg::val_type'(mag_w) : ibqm_pkg::val_type'(mag_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            ua_ff   <= ibqm_pkg::mag64(op_a);
            ub_ff   <= ibqm_pkg::mag64(op_b);
            neg_ff  <= op_a[63] ^ op_b[63];
            sh_ff   <= req.shift;
            acc_ff  <= 128'd0;
            cnt_ff  <= 3'd0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (cnt_ff == 3'd4) begin
               res_ff  <= res_in;
               done_ff <= 1'b1;
               busy_ff <= 1'b0;
            end else begin
               acc_ff <= acc_in;
               cnt_ff <= cnt_ff + 3'd1;
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule
`default_nettype wire

// ----- design/ibqm_div.sv -----
// Restoring divider, one quotient bit per cycle: (num * 2^FN) / den, saturated.
`default_nettype none
module ibqm_div (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   input  ibqm_pkg::val_type  num,
   input  ibqm_pkg::val_type  den,
   output logic               done,
   output ibqm_pkg::val_type  quot
);

   localparam int unsigned DW = ibqm_pkg::DIV_W;
   localparam int unsigned CW = ibqm_pkg::DIV_CNT_W;

   logic [DW-1:0] dvd_ff, q_ff;
   logic [64:0]   rem_ff, rem_sh, rem_in;
   logic [63:0]   ud_ff;
   logic          neg_ff, busy_ff, done_ff, qbit;
   logic [CW-1:0] cnt_ff;
   logic [63:0]   qmag;

   // one restoring step
   always_comb begin
      rem_sh = {rem_ff[63:0], dvd_ff[DW-1]};
      qbit   = (rem_sh >= {1'b0, ud_ff});
      rem_in = qbit ? (rem_sh - {1'b0, ud_ff}) : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            dvd_ff  <= DW'(ibqm_pkg::mag64(num)) << ibqm_pkg::FN;
            ud_ff   <= ibqm_pkg::mag64(den);
            neg_ff  <= num[63] ^ den[63];
            rem_ff  <= 65'd0;
            q_ff    <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= dvd_ff << 1;
            q_ff   <= {q_ff[DW-2:0], qbit};
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(DW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // saturate the quotient and apply sign
   always_comb begin
      if (q_ff[DW-1:63] != '0) qmag = 64'(ibqm_pkg::SMAX);
      else qmag = q_ff[63:0];
      quot = neg_ff ? -ibqm_pkg::val_type'(qmag) : ibqm_pkg::val_type'(qmag);
   end

   assign done = done_ff;

endmodule
`default_nettype wire

// ----- design/inverse_bilinear_quad_map.sv -----
// Top level: inverse bilinear quad map, Newton sequencer around a shared multiplier and divider.
//
// Usage: one input beat (lon, lat, signed Q9.22) on req_* gives one result beat on rsp_*
// (grid_x, grid_y in signed Q32.16, status on rsp_tuser). The four corners and the grid
// extents are written over the csr_* port while the block is idle; writes take effect at
// once and reads return the stored values.
// Sequence: each Newton iteration runs 19 multiply steps on the shared multiplier (each
// step: issue, four 32x32 partial products, shift/saturate and write-back), two divisions
// on the bit-serial divider and one update state. An item takes the accept state, one to
// ten iterations, two scaling multiplies and the output load. A singular Jacobian ends the
// item early. The block takes one item at a time; req_tready is high only while it waits
// for an item. The result sits in an output register; a stalled receiver holds the
// sequencer at its last step until rsp_tready frees the register, and a new item can be
// accepted while a result still waits.
// Reset: corners clear to zero, grid extents to one, no result pending.
`default_nettype none
module inverse_bilinear_quad_map (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [63:0]  req_tdata,    // lon [31:0], lat [63:32]
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [103:0] rsp_tdata,    // grid_x [48:0], grid_y [97:49], zero fill
   output logic         rsp_tuser,    // status
   input  wire          csr_psel,
   input  wire          csr_penable,
   input  wire          csr_pwrite,
   input  wire  [5:0]   csr_paddr,
   input  wire  [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_GO   = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_UPD  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   localparam logic [2:0] R_CA = 3'd0;
   localparam logic [2:0] R_CB = 3'd1;
   localparam logic [2:0] R_CC = 3'd2;
   localparam logic [2:0] R_CD = 3'd3;
   localparam logic [2:0] R_GW = 3'd4;
   localparam logic [2:0] R_GH = 3'd5;

   localparam int unsigned IW = ibqm_pkg::ITER_W;

   // configuration
   logic [63:0] ca_ff, cb_ff, cc_ff, cd_ff;
   logic [23:0] gw_ff, gh_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ca_ff <= 64'd0;
         cb_ff <= 64'd0;
         cc_ff <= 64'd0;
         cd_ff <= 64'd0;
         gw_ff <= 24'd1;
         gh_ff <= 24'd1;
      end else if (csr_wr) begin
         case (csr_paddr[5:3])
            R_CA:    ca_ff <= csr_pwdata;
            R_CB:    cb_ff <= csr_pwdata;
            R_CC:    cc_ff <= csr_pwdata;
            R_CD:    cd_ff <= csr_pwdata;
            R_GW:    gw_ff <= csr_pwdata[23:0];
            R_GH:    gh_ff <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[5:3])
         R_CA:    csr_prdata = ca_ff;
         R_CB:    csr_prdata = cb_ff;
         R_CC:    csr_prdata = cc_ff;
         R_CD:    csr_prdata = cd_ff;
         R_GW:    csr_prdata = 64'(gw_ff);
         R_GH:    csr_prdata = 64'(gh_ff);
         default: csr_prdata = 64'd0;
      endcase
   end

   // corner sums and Jacobian terms, Q.22
   ibqm_pkg::val_type u0, u1, u2, u3, v0, v1, v2, v3;
   ibqm_pkg::val_type j1x, j1y, k1x, k1y, cx, cy, su, sv;

   always_comb begin
      u0 = 64'(signed'(ca_ff[31:0]));
      u1 = 64'(signed'(cb_ff[31:0]));
      u2 = 64'(signed'(cc_ff[31:0]));
      u3 = 64'(signed'(cd_ff[31:0]));
      v0 = 64'(signed'(ca_ff[63:32]));
      v1 = 64'(signed'(cb_ff[63:32]));
      v2 = 64'(signed'(cc_ff[63:32]));
      v3 = 64'(signed'(cd_ff[63:32]));
      j1x = -u0 - u1 + u2 + u3;
      j1y = -u0 + u1 + u2 - u3;
      k1x = -v0 - v1 + v2 + v3;
      k1y = -v0 + v1 + v2 - v3;
      cx  = u0 - u1 + u2 - u3;
      cy  = v0 - v1 + v2 - v3;
      su  = u0 + u1 + u2 + u3;
      sv  = v0 + v1 + v2 + v3;
   end

   // sequencer state and working registers
   logic [2:0]    state_ff;
   logic [4:0]    step_ff;
   logic [IW-1:0] iter_ff;
   ibqm_pkg::val_type x_ff, y_ff, a_ff, b_ff, c_ff, d_ff, xy_ff, t_ff, det_ff;
   ibqm_pkg::val_type p_ff, q_ff, dx_ff, dy_ff, p0_ff, q0_ff;
   logic signed [48:0] ox_ff, oy_ff;
   logic          fail_ff;
   logic          rsp_valid_ff;
   logic [103:0]  rsp_data_ff;
   logic          rsp_user_ff;
   logic          rsp_load;

   ibqm_pkg::step_type   st;
   ibqm_pkg::mul_req_type mreq;
   ibqm_pkg::val_type    opa, opb, base, prod, wb, quot;
   ibqm_pkg::val_type    lon4, lat4, clamp_o;
   logic                 mul_done, div_done, div_start;

   assign st = ibqm_pkg::step_info(step_ff);

   function automatic ibqm_pkg::val_type pick(input logic [4:0] sel,
         input ibqm_pkg::val_type xv, input ibqm_pkg::val_type yv,
         input ibqm_pkg::val_type av, input ibqm_pkg::val_type bv,
         input ibqm_pkg::val_type cv, input ibqm_pkg::val_type dv,
         input ibqm_pkg::val_type xyv, input ibqm_pkg::val_type pv,
         input ibqm_pkg::val_type qv, input ibqm_pkg::val_type dxv,
         input ibqm_pkg::val_type dyv, input ibqm_pkg::val_type cxv,
         input ibqm_pkg::val_type cyv, input ibqm_pkg::val_type j1xv,
         input ibqm_pkg::val_type j1yv, input ibqm_pkg::val_type k1xv,
         input ibqm_pkg::val_type k1yv, input logic [23:0] gwv,
         input logic [23:0] ghv);
      ibqm_pkg::val_type r;
      case (sel)
         ibqm_pkg::OP_X:   r = xv;
         ibqm_pkg::OP_Y:   r = yv;
         ibqm_pkg::OP_A:   r = av;
         ibqm_pkg::OP_B:   r = bv;
         ibqm_pkg::OP_C:   r = cv;
         ibqm_pkg::OP_D:   r = dv;
         ibqm_pkg::OP_XY:  r = xyv;
         ibqm_pkg::OP_P:   r = pv;
         ibqm_pkg::OP_Q:   r = qv;
         ibqm_pkg::OP_DX:  r = dxv;
         ibqm_pkg::OP_DY:  r = dyv;
         ibqm_pkg::OP_CX:  r = cxv;
         ibqm_pkg::OP_CY:  r = cyv;
         ibqm_pkg::OP_J1X: r = j1xv;
         ibqm_pkg::OP_J1Y: r = j1yv;
         ibqm_pkg::OP_K1X: r = k1xv;
         ibqm_pkg::OP_K1Y: r = k1yv;
         ibqm_pkg::OP_GW:  r = 64'(gwv);
         ibqm_pkg::OP_GH:  r = 64'(ghv);
         ibqm_pkg::OP_X1:  r = ibqm_pkg::sat_add(xv, ibqm_pkg::ONE_N);
         ibqm_pkg::OP_Y1:  r = ibqm_pkg::sat_add(yv, ibqm_pkg::ONE_N);
         default:          r = 64'sd0;
      endcase
      return r;
   endfunction

   // operand selection for the multiplier
   always_comb begin
      opa = pick(st.a_sel, x_ff, y_ff, a_ff, b_ff, c_ff, d_ff, xy_ff, p_ff, q_ff, dx_ff,
                 dy_ff, cx, cy, j1x, j1y, k1x, k1y, gw_ff, gh_ff);
      opb = pick(st.b_sel, x_ff, y_ff, a_ff, b_ff, c_ff, d_ff, xy_ff, p_ff, q_ff, dx_ff,
                 dy_ff, cx, cy, j1x, j1y, k1x, k1y, gw_ff, gh_ff);
      mreq.start = (state_ff == S_GO);
      mreq.shift = st.shift;
   end

   ibqm_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .req    (mreq),
      .op_a   (opa),
      .op_b   (opb),
      .done   (mul_done),
      .result (prod)
   );

   // accumulate the product onto its base
   always_comb begin
      case (st.base_sel)
         ibqm_pkg::BS_J1X: base = j1x;
         ibqm_pkg::BS_J1Y: base = j1y;
         ibqm_pkg::BS_K1X: base = k1x;
         ibqm_pkg::BS_K1Y: base = k1y;
         ibqm_pkg::BS_T:   base = t_ff;
         ibqm_pkg::BS_P:   base = p_ff;
         ibqm_pkg::BS_Q:   base = q_ff;
         ibqm_pkg::BS_P0:  base = p0_ff;
         ibqm_pkg::BS_Q0:  base = q0_ff;
         default:          base = 64'sd0;
      endcase
      wb = st.sub ? ibqm_pkg::sat65(65'(base) - 65'(prod))
                  : ibqm_pkg::sat65(65'(base) + 65'(prod));
      if (wb > ibqm_pkg::OUT_MAX) clamp_o = ibqm_pkg::OUT_MAX;
      else if (wb < ibqm_pkg::OUT_MIN) clamp_o = ibqm_pkg::OUT_MIN;
      else clamp_o = wb;
      lon4 = 64'(signed'(req_tdata[31:0])) <<< 2;
      lat4 = 64'(signed'(req_tdata[63:32])) <<< 2;
   end

   assign div_start = (state_ff == S_MUL) && mul_done &&
                      ((step_ff == ibqm_pkg::ST_DXN) || (step_ff == ibqm_pkg::ST_DYN));

   ibqm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (wb),
      .den   (det_ff),
      .done  (div_done),
      .quot  (quot)
   );

   assign req_tready = (state_ff == S_IDLE);

   // output register loads once it is free or being emptied
   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   // Newton sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= ibqm_pkg::ST_FIRST;
         iter_ff      <= '0;
         fail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  p0_ff    <= ibqm_pkg::sat65(65'(lon4) - 65'(su));
                  q0_ff    <= ibqm_pkg::sat65(65'(lat4) - 65'(sv));
                  x_ff     <= 64'sd0;
                  y_ff     <= 64'sd0;
                  iter_ff  <= '0;
                  step_ff  <= ibqm_pkg::ST_FIRST;
                  fail_ff  <= 1'b0;
                  state_ff <= S_GO;
               end
            end
            S_GO: state_ff <= S_MUL;
            S_MUL: begin
               if (mul_done) begin
                  case (st.dest)
                     ibqm_pkg::DS_A:   a_ff   <= wb;
                     ibqm_pkg::DS_B:   b_ff   <= wb;
                     ibqm_pkg::DS_C:   c_ff   <= wb;
                     ibqm_pkg::DS_D:   d_ff   <= wb;
                     ibqm_pkg::DS_XY:  xy_ff  <= wb;
                     ibqm_pkg::DS_DET: det_ff <= wb;
                     ibqm_pkg::DS_P:   p_ff   <= wb;
                     ibqm_pkg::DS_Q:   q_ff   <= wb;
                     ibqm_pkg::DS_OX:  ox_ff  <= clamp_o[48:0];
                     ibqm_pkg::DS_OY:  oy_ff  <= clamp_o[48:0];
                     default:          t_ff   <= wb;
                  endcase
                  if (step_ff == ibqm_pkg::ST_DET && wb == 64'sd0) begin
                     fail_ff  <= 1'b1;
                     state_ff <= S_OUT;
                  end else if (div_start) begin
                     state_ff <= S_DIV;
                  end else if (step_ff == ibqm_pkg::ST_SQ) begin
                     if (wb <= ibqm_pkg::RES_LIMIT) begin
                        step_ff  <= step_ff + 5'd1;
                        state_ff <= S_GO;
                     end else if (iter_ff == IW'(ibqm_pkg::MAX_ITERATIONS - 1)) begin
                        fail_ff  <= 1'b1;
                        state_ff <= S_OUT;
                     end else begin
                        iter_ff  <= iter_ff + IW'(1);
                        step_ff  <= ibqm_pkg::ST_FIRST;
                        state_ff <= S_GO;
                     end
                  end else if (step_ff == ibqm_pkg::ST_OY) begin
                     state_ff <= S_OUT;
                  end else begin
                     step_ff  <= step_ff + 5'd1;
                     state_ff <= S_GO;
                  end
               end
            end
            S_DIV: begin
               if (div_done) begin
                  if (step_ff == ibqm_pkg::ST_DXN) begin
                     dx_ff    <= quot;
                     step_ff  <= step_ff + 5'd1;
                     state_ff <= S_GO;
                  end else begin
                     dy_ff    <= quot;
                     state_ff <= S_UPD;
                  end
               end
            end
            S_UPD: begin
               x_ff     <= ibqm_pkg::sat_add(x_ff, dx_ff);
               y_ff     <= ibqm_pkg::sat_add(y_ff, dy_ff);
               step_ff  <= ibqm_pkg::ST_SQ0;
               state_ff <= S_GO;
            end
            S_OUT: begin
               if (rsp_load) begin
                  rsp_user_ff  <= fail_ff;
                  rsp_data_ff  <= fail_ff ? 104'd0
                                          : {6'd0, 49'(oy_ff), 49'(ox_ff)};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // error results carry zero coordinates
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 104'd0))
      else $error("error result with nonzero coordinates");

   // multiplier only finishes while the sequencer waits on it
   a_mul_owner: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_MUL))
      else $error("multiplier done outside multiply wait");

   // divider only finishes while the sequencer waits on it
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider done outside divide wait");

   // iteration count stays below the limit
   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      iter_ff < IW'(ibqm_pkg::MAX_ITERATIONS))
      else $error("iteration count out of range");

   // a new result is only loaded once the output register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("pending result overwritten");

endmodule
`default_nettype wire

// ----- tb/tb_ibqm_pkg.sv -----
// Register map shared by the quad map testbench stimulus and checker.
package tb_ibqm_pkg;

   localparam logic [2:0] REG_CORNER_A    = 3'd0;
   localparam logic [2:0] REG_CORNER_B    = 3'd1;
   localparam logic [2:0] REG_CORNER_C    = 3'd2;
   localparam logic [2:0] REG_CORNER_D    = 3'd3;
   localparam logic [2:0] REG_GRID_WIDTH  = 3'd4;
   localparam logic [2:0] REG_GRID_HEIGHT = 3'd5;
   localparam logic [2:0] REG_UNUSED_6    = 3'd6;
   localparam logic [2:0] REG_UNUSED_7    = 3'd7;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

endpackage

// ----- tb/ibqm_checker.sv -----
// Checker: mirrors register writes, predicts each grid result and compares it on the rsp side.
module ibqm_checker
   import ibqm_pkg::*;
   import tb_ibqm_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   input  wire          req_tready,
   input  wire  [63:0]  req_tdata,    // lon [31:0], lat [63:32]
   input  wire          rsp_tvalid,
   input  wire          rsp_tready,
   input  wire  [103:0] rsp_tdata,    // grid_x [48:0], grid_y [97:49], zero fill
   input  wire          rsp_tuser,    // status
   input  wire          csr_psel,
   input  wire          csr_penable,
   input  wire          csr_pwrite,
   input  wire  [5:0]   csr_paddr,
   input  wire  [63:0]  csr_pwdata,
   input  wire          csr_pready,
   output int unsigned  mismatch_count,
   output int unsigned  grid_pending
);

   typedef struct packed {
      logic [48:0] grid_x;
      logic [48:0] grid_y;
      logic        status;
   } grid_point_type;

   logic [63:0] corner_q [4];
   logic [23:0] width_q;
   logic [23:0] height_q;
   grid_point_type grid_expected [$];

   assign grid_pending = grid_expected.size();

   function automatic val_type sum_sat(input val_type a, input val_type b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s > $signed({1'b0, SMAX})) return SMAX;
      if (s < -$signed({1'b0, SMAX})) return -SMAX;
      return s[63:0];
   endfunction

   function automatic val_type diff_sat(input val_type a, input val_type b);
      return sum_sat(a, (b == {1'b1, 63'd0}) ? SMAX : -b);
   endfunction

   function automatic logic [63:0] abs64(input val_type a);
      return a[63] ? 64'd0 - 64'(a) : 64'(a);
   endfunction

   // exact product, shifted right, truncated toward zero, saturated
   function automatic val_type prod_shift(input val_type a, input val_type b,
                                          input int unsigned sh);
      logic [127:0] p;
      logic [63:0]  m;
      p = ({64'd0, abs64(a)} * {64'd0, abs64(b)}) >> sh;
      m = (p > {64'd0, SMAX}) ? SMAX : p[63:0];
      return (a[63] != b[63]) ? -$signed(m) : $signed(m);
   endfunction

   // (n << sh) / d, truncated toward zero, saturated
   function automatic val_type quot_shift(input val_type n, input val_type d,
                                          input int unsigned sh);
      logic [127:0] q;
      logic [63:0]  m;
      q = ({64'd0, abs64(n)} << sh) / {64'd0, abs64(d)};
      m = (q > {64'd0, SMAX}) ? SMAX : q[63:0];
      return (n[63] != d[63]) ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic [48:0] clamp_out(input val_type v);
      val_type c;
      c = v;
      if (c > OUT_MAX) c = OUT_MAX;
      if (c < OUT_MIN) c = OUT_MIN;
      return c[48:0];
   endfunction

   // Newton inversion of the bilinear quad for one point
   function automatic grid_point_type map_point(input logic [63:0] pt);
      val_type u [4];
      val_type v [4];
      val_type j1x, j1y, k1x, k1y, cx, cy, su, sv, lon4, lat4;
      val_type x, y, a, b, c, d, xy, det, p, q, dx, dy, sq;
      logic done;
      grid_point_type r;
      for (int i = 0; i < 4; i++) begin
         u[i] = 64'($signed(corner_q[i][31:0]));
         v[i] = 64'($signed(corner_q[i][63:32]));
      end
      j1x = -u[0] - u[1] + u[2] + u[3];
      j1y = -u[0] + u[1] + u[2] - u[3];
      k1x = -v[0] - v[1] + v[2] + v[3];
      k1y = -v[0] + v[1] + v[2] - v[3];
      cx = u[0] - u[1] + u[2] - u[3];
      cy = v[0] - v[1] + v[2] - v[3];
      su = u[0] + u[1] + u[2] + u[3];
      sv = v[0] + v[1] + v[2] + v[3];
      lon4 = 64'($signed(pt[31:0])) * 4;
      lat4 = 64'($signed(pt[63:32])) * 4;
      x = 0;
      y = 0;
      done = 1'b0;
      for (int k = 0; k < MAX_ITERATIONS && !done; k++) begin
         a = sum_sat(j1x, prod_shift(y, cx, FN));
         b = sum_sat(j1y, prod_shift(x, cx, FN));
         c = sum_sat(k1x, prod_shift(y, cy, FN));
         d = sum_sat(k1y, prod_shift(x, cy, FN));
         xy = prod_shift(x, y, FN);
         det = diff_sat(prod_shift(a, d, FC), prod_shift(c, b, FC));
         if (det == 0) break;
         p = diff_sat(lon4, su);
         p = diff_sat(p, prod_shift(j1x, x, FN));
         p = diff_sat(p, prod_shift(j1y, y, FN));
         p = diff_sat(p, prod_shift(cx, xy, FN));
         q = diff_sat(lat4, sv);
         q = diff_sat(q, prod_shift(k1x, x, FN));
         q = diff_sat(q, prod_shift(k1y, y, FN));
         q = diff_sat(q, prod_shift(cy, xy, FN));
         dx = quot_shift(diff_sat(prod_shift(d, p, FC), prod_shift(b, q, FC)), det, FN);
         dy = quot_shift(diff_sat(prod_shift(a, q, FC), prod_shift(c, p, FC)), det, FN);
         x = sum_sat(x, dx);
         y = sum_sat(y, dy);
         sq = sum_sat(prod_shift(dx, dx, 0), prod_shift(dy, dy, 0));
         if (sq <= RES_LIMIT) done = 1'b1;
      end
      if (done) begin
         r.grid_x = clamp_out(prod_shift(sum_sat(x, ONE_N), 64'(width_q), FOUT));
         r.grid_y = clamp_out(prod_shift(sum_sat(y, ONE_N), 64'(height_q), FOUT));
         r.status = STATUS_OK;
      end else begin
         r = '{49'd0, 49'd0, STATUS_FAIL};
      end
      return r;
   endfunction

   // register mirror, prediction on req beats, compare on rsp beats
   always @(posedge clock) begin
      grid_point_type want;
      grid_point_type got;
      if (reset) begin
         for (int i = 0; i < 4; i++) corner_q[i] <= '0;
         width_q <= 24'd1;
         height_q <= 24'd1;
         mismatch_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[5:3])
               REG_CORNER_A:    corner_q[0] <= csr_pwdata;
               REG_CORNER_B:    corner_q[1] <= csr_pwdata;
               REG_CORNER_C:    corner_q[2] <= csr_pwdata;
               REG_CORNER_D:    corner_q[3] <= csr_pwdata;
               REG_GRID_WIDTH:  width_q <= csr_pwdata[23:0];
               REG_GRID_HEIGHT: height_q <= csr_pwdata[23:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) grid_expected.push_back(map_point(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[48:0], rsp_tdata[97:49], rsp_tuser};
            if (grid_expected.size() == 0) begin
               $display("%0t: unexpected rsp beat %h", $realtime, got);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = grid_expected.pop_front();
               if (got.grid_x !== want.grid_x || got.grid_y !== want.grid_y ||
                   got.status !== want.status) begin
                  $display("%0t: expected x=%h y=%h st=%b, actual x=%h y=%h st=%b",
                           $realtime, want.grid_x, want.grid_y, want.status,
                           got.grid_x, got.grid_y, got.status);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end

endmodule

// ----- tb/tb_inverse_bilinear_quad_map.sv -----
// Testbench top: clock, reset, register setup, point stimulus, result back-pressure and verdict.
module tb_inverse_bilinear_quad_map;
   import tb_ibqm_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 20_000_000;
   localparam int unsigned PHASES = 10;
   localparam int unsigned PHASE_BEATS = 103;
   localparam int unsigned LONG_HOLD = 8000;
   localparam logic signed [31:0] DEG = 32'sd4194304;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [63:0]   req_tdata = '0;   // lon [31:0], lat [63:32]
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [103:0]  rsp_tdata;        // grid_x [48:0], grid_y [97:49], zero fill
   logic          rsp_tuser;        // status
   logic          csr_psel = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite = 1'b0;
   logic [5:0]    csr_paddr = '0;
   logic [63:0]   csr_pwdata = '0;
   logic [63:0]   csr_prdata;
   logic          csr_pready;

   int unsigned   mismatch_count;
   int unsigned   grid_pending;
   int unsigned   cycle_count = 0;
   logic          quiet = 1'b0;      // no idling on either side
   logic          hold_req = 1'b0;   // ask the receiver for one long hold-off
   logic          gaps_on = 1'b1;

   // quad geometry of the current phase
   logic signed [31:0] ctr_lon, ctr_lat, span;

   inverse_bilinear_quad_map u_top (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   ibqm_checker u_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .mismatch_count, .grid_pending
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      int unsigned stall_left;
      int unsigned hold_left;
      logic hold_done;
      stall_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (quiet) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 8);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // one point beat; valid stays up for a following beat unless a gap is taken
   task automatic send_point(input logic signed [31:0] lon, input logic signed [31:0] lat);
      logic taken;
      req_tvalid <= 1'b1;
      req_tdata <= {lat, lon};
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end
      if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (grid_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [63:0] pack_corner(input logic signed [31:0] lon,
                                               input logic signed [31:0] lat);
      return {lat, lon};
   endfunction

   function automatic logic signed [31:0] jitter(input logic signed [31:0] r);
      return $signed($urandom_range(0, 2 * r)) - r;
   endfunction

   // set up a quad around a random center; skew distorts the corners
   task automatic load_quad(input logic signed [31:0] half, input logic skewed,
                            input logic [23:0] w, input logic [23:0] h);
      logic signed [31:0] jr;
      ctr_lon = $signed($urandom) >>> 2;
      ctr_lat = $signed($urandom) >>> 3;
      span = half;
      jr = skewed ? half / 3 : 0;
      csr_write(REG_CORNER_A, pack_corner(ctr_lon - half + jitter(jr),
                                          ctr_lat - half + jitter(jr)));
      csr_write(REG_CORNER_B, pack_corner(ctr_lon - half + jitter(jr),
                                          ctr_lat + half + jitter(jr)));
      csr_write(REG_CORNER_C, pack_corner(ctr_lon + half + jitter(jr),
                                          ctr_lat + half + jitter(jr)));
      csr_write(REG_CORNER_D, pack_corner(ctr_lon + half + jitter(jr),
                                          ctr_lat - half + jitter(jr)));
      csr_write(REG_GRID_WIDTH, {40'd0, w});
      csr_write(REG_GRID_HEIGHT, {40'd0, h});
   endtask

   function automatic logic [23:0] pick_grid();
      case ($urandom_range(0, 9))
         0: return 24'd0;
         1: return 24'hFFFFFF;
         2: return 24'd1;
         default: return 24'($urandom_range(1, 4096));
      endcase
   endfunction

   // mostly points around the quad, some anywhere
   task automatic random_point();
      if ($urandom_range(0, 9) == 0)
         send_point($signed($urandom), $signed($urandom));
      else
         send_point(ctr_lon + jitter(span + span / 4), ctr_lat + jitter(span + span / 4));
   endtask

   initial begin
      logic signed [31:0] half;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset corners are all zero: singular Jacobian
      send_point(32'sd0, 32'sd0);
      send_point(32'sh7FFFFFFF, 32'sh80000000);
      wait_idle();

      // directed: regular one-degree quad, corners, center, outside, field extremes
      ctr_lon = -32'sd120 * DEG;
      ctr_lat = 32'sd34 * DEG;
      span = DEG / 2;
      csr_write(REG_CORNER_A, pack_corner(ctr_lon - span, ctr_lat - span));
      csr_write(REG_CORNER_B, pack_corner(ctr_lon - span, ctr_lat + span));
      csr_write(REG_CORNER_C, pack_corner(ctr_lon + span, ctr_lat + span));
      csr_write(REG_CORNER_D, pack_corner(ctr_lon + span, ctr_lat - span));
      csr_write(REG_GRID_WIDTH, 64'd1000);
      csr_write(REG_GRID_HEIGHT, 64'd500);
      csr_write(REG_UNUSED_6, '1);
      csr_write(REG_UNUSED_7, '1);
      send_point(ctr_lon, ctr_lat);
      send_point(ctr_lon - span, ctr_lat - span);
      send_point(ctr_lon + span, ctr_lat + span);
      send_point(ctr_lon - span, ctr_lat + span);
      send_point(ctr_lon + 3 * span, ctr_lat - 5 * span);
      send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF);
      send_point(32'sh80000000, 32'sh80000000);
      send_point(32'sh7FFFFFFF, 32'sh80000000);
      send_point(32'sd0, 32'sd0);
      send_point(32'shFFFFFFFF, 32'sh55555555);
      wait_idle();

      // extreme corners and grid extents
      csr_write(REG_CORNER_A, {32'h80000000, 32'h80000000});
      csr_write(REG_CORNER_B, {32'h7FFFFFFF, 32'h80000000});
      csr_write(REG_CORNER_C, {32'h7FFFFFFF, 32'h7FFFFFFF});
      csr_write(REG_CORNER_D, {32'h80000000, 32'h7FFFFFFF});
      csr_write(REG_GRID_WIDTH, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(REG_GRID_HEIGHT, 64'd0);
      send_point(32'sd0, 32'sd0);
      send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF);
      send_point(32'sh80000000, 32'sh12345678);
      send_point(32'sh40000000, 32'shC0000000);
      wait_idle();

      // degenerate quad: all corners on one line
      csr_write(REG_CORNER_A, pack_corner(DEG, DEG));
      csr_write(REG_CORNER_B, pack_corner(2 * DEG, 2 * DEG));
      csr_write(REG_CORNER_C, pack_corner(3 * DEG, 3 * DEG));
      csr_write(REG_CORNER_D, pack_corner(4 * DEG, 4 * DEG));
      send_point(2 * DEG, 2 * DEG);
      send_point(DEG, 3 * DEG);
      wait_idle();

      // random phases
      for (int ph = 0; ph < PHASES; ph++) begin
         case ($urandom_range(0, 3))
            0: half = 32'($urandom_range(1 << 10, 1 << 16));
            1: half = 32'($urandom_range(1 << 22, 1 << 26));
            default: half = 32'($urandom_range(1 << 16, 1 << 22));
         endcase
         if (ph == PHASES - 1) quiet = 1'b1;
         load_quad(half, ph % 3 != 0, pick_grid(), pick_grid());
         if (ph == 2) hold_req = 1'b1;
         for (int i = 0; i < PHASE_BEATS; i++) begin
            if (ph == 4 && i == PHASE_BEATS / 2) begin
               // sender waits for every result to drain
               req_tvalid <= 1'b0;
               while (grid_pending != 0) @(posedge clock);
            end
            random_point();
         end
         wait_idle();
      end

      repeat (400) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
